[hw/rtl/ccfp_pkg.sv]
// Shared types, constants and byte-level helpers of the CRC-checked frame parser.
`default_nettype none

package ccfp_pkg;

  localparam int NUM_IDS_DEF      = 5;
  localparam int REPLY_LENGTH     = 6;
  localparam int SLOT_W           = 3;
  localparam int BYTE_W           = 8;
  localparam int CRC_W            = 16;
  localparam int TABLE_W          = 40;
  localparam int REPLY_LOW_W      = 64;
  localparam int REPLY_HIGH_W     = 56;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_INDEX_W      = 3;
  localparam int REPLY_IDX_W      = 3;

  localparam logic [CRC_W-1:0]  CRC_POLY         = 16'h8005;
  localparam logic [CRC_W-1:0]  CRC_INIT         = 16'hFFFF;
  localparam logic [BYTE_W-1:0] MIN_FRAME_LENGTH = 8'd5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ID_TABLE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_TABLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLY_LOW    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLY_HIGH   = 3'd3;

  // Reply sequence positions
  localparam logic [REPLY_IDX_W-1:0] RPL_CRC_HI = 3'd4;
  localparam logic [REPLY_IDX_W-1:0] RPL_CRC_LO = 3'd5;

  typedef enum logic [2:0] {
    ST_WAIT_ID     = 3'd0,
    ST_WAIT_LEN    = 3'd1,
    ST_WAIT_DATA   = 3'd2,
    ST_WAIT_CRC_HI = 3'd3,
    ST_WAIT_CRC_LO = 3'd4
  } parse_state_t;

  // Start request from the parser to the reply sequencer
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } reply_req_t;

  // CRC-16/CMS, one byte, MSB first
  function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Byte of a slot table; slots past the register read as zero
  function automatic logic [BYTE_W-1:0] table_byte(input logic [TABLE_W-1:0] tbl,
                                                   input logic [SLOT_W-1:0] slot);
    logic [63:0] ext;
    ext = {24'h0, tbl};
    return ext[{slot, 3'b000} +: BYTE_W];
  endfunction

  // Reply byte n of the combined reply registers; past byte 14 reads zero
  function automatic logic [BYTE_W-1:0] reply_byte(input logic [REPLY_LOW_W-1:0] low,
                                                   input logic [REPLY_HIGH_W-1:0] high,
                                                   input logic [4:0] n);
    logic [255:0] ext;
    ext = {136'h0, high, low};
    return ext[{n, 3'b000} +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ccfp_cfg_regs.sv]
// Configuration register file of the CRC-checked frame parser.
`default_nettype none

module ccfp_cfg_regs
  import ccfp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  output logic [TABLE_W-1:0]           id_table,
  output logic [TABLE_W-1:0]           length_table,
  output logic [REPLY_LOW_W-1:0]       reply_low,
  output logic [REPLY_HIGH_W-1:0]      reply_high
);

  logic [TABLE_W-1:0]      id_table_r, id_table_nxt;
  logic [TABLE_W-1:0]      length_table_r, length_table_nxt;
  logic [REPLY_LOW_W-1:0]  reply_low_r, reply_low_nxt;
  logic [REPLY_HIGH_W-1:0] reply_high_r, reply_high_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    id_table_nxt     = id_table_r;
    length_table_nxt = length_table_r;
    reply_low_nxt    = reply_low_r;
    reply_high_nxt   = reply_high_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ID_TABLE:     id_table_nxt     = cfg_data[TABLE_W-1:0];
        REG_LENGTH_TABLE: length_table_nxt = cfg_data[TABLE_W-1:0];
        REG_REPLY_LOW:    reply_low_nxt    = cfg_data[REPLY_LOW_W-1:0];
        REG_REPLY_HIGH:   reply_high_nxt   = cfg_data[REPLY_HIGH_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_table_r     <= '0;
      length_table_r <= '0;
      reply_low_r    <= '0;
      reply_high_r   <= '0;
    end else begin
      id_table_r     <= id_table_nxt;
      length_table_r <= length_table_nxt;
      reply_low_r    <= reply_low_nxt;
      reply_high_r   <= reply_high_nxt;
    end
  end

  assign id_table     = id_table_r;
  assign length_table = length_table_r;
  assign reply_low    = reply_low_r;
  assign reply_high   = reply_high_r;

endmodule

`default_nettype wire

[hw/rtl/ccfp_parser.sv]
// Frame parser: ID hunt, length check, running CRC and CRC compare.
`default_nettype none

module ccfp_parser
  import ccfp_pkg::*;
#(
  parameter int NUM_IDS = NUM_IDS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [BYTE_W-1:0]        rx_byte,
  input  wire logic [TABLE_W-1:0]       id_table,
  input  wire logic [TABLE_W-1:0]       length_table,
  input  wire logic [REPLY_LOW_W-1:0]   reply_low,
  input  wire logic [REPLY_HIGH_W-1:0]  reply_high,
  input  wire logic                     reply_busy,
  output reply_req_t                    req
);

  parse_state_t      state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [BYTE_W-1:0] id_r, id_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] idx_r, idx_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] crc_hi_r, crc_hi_nxt;

  logic              accept;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic [BYTE_W-1:0] want_len;
  logic [BYTE_W-1:0] idx_inc;
  logic [4:0]        rb_base;
  logic [CRC_W-1:0]  crc_step;

  // Hold off the CRC low byte while the previous reply still drains
  assign in_tready = !((state_r == ST_WAIT_CRC_LO) && reply_busy);
  assign accept    = in_tvalid && in_tready;

  // Lowest matching slot wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = NUM_IDS - 1; s >= 0; s--) begin
      if (table_byte(id_table, SLOT_W'(s)) == rx_byte) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(s);
      end
    end
  end

  assign want_len = table_byte(length_table, slot_r);
  assign idx_inc  = idx_r + 8'd1;
  assign rb_base  = ({2'b00, slot_r} << 1) + {2'b00, slot_r};
  assign crc_step = crc16_update(crc_r, rx_byte);

  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    crc_hi_nxt = crc_hi_r;
    req        = '0;
    if (accept) begin
      unique case (state_r)
        ST_WAIT_ID: begin
          if (hit) begin
            slot_nxt  = hit_slot;
            id_nxt    = rx_byte;
            idx_nxt   = 8'd1;
            crc_nxt   = crc16_update(CRC_INIT, rx_byte);
            state_nxt = ST_WAIT_LEN;
          end
        end
        ST_WAIT_LEN: begin
          if ((rx_byte == want_len) && (want_len >= MIN_FRAME_LENGTH)) begin
            len_nxt   = rx_byte;
            idx_nxt   = 8'd2;
            crc_nxt   = crc_step;
            state_nxt = ST_WAIT_DATA;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_WAIT_ID;
          end
        end
        ST_WAIT_DATA: begin
          crc_nxt = crc_step;
          idx_nxt = idx_inc;
          if (({2'b00, idx_inc} + 10'd2) >= {2'b00, len_r}) begin
            state_nxt = ST_WAIT_CRC_HI;
          end
        end
        ST_WAIT_CRC_HI: begin
          crc_hi_nxt = rx_byte;
          idx_nxt    = idx_inc;
          state_nxt  = ST_WAIT_CRC_LO;
        end
        ST_WAIT_CRC_LO: begin
          idx_nxt   = '0;
          state_nxt = ST_WAIT_ID;
          if ({crc_hi_r, rx_byte} == crc_r) begin
            req.valid = 1'b1;
            req.id    = id_r;
            req.b1    = reply_byte(reply_low, reply_high, rb_base);
            req.b2    = reply_byte(reply_low, reply_high, rb_base + 5'd1);
            req.b3    = reply_byte(reply_low, reply_high, rb_base + 5'd2);
          end
        end
        default: begin
          idx_nxt   = '0;
          state_nxt = ST_WAIT_ID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_WAIT_ID;
      slot_r   <= '0;
      id_r     <= '0;
      len_r    <= '0;
      idx_r    <= '0;
      crc_r    <= CRC_INIT;
      crc_hi_r <= '0;
    end else begin
      state_r  <= state_nxt;
      slot_r   <= slot_nxt;
      id_r     <= id_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ccfp_reply.sv]
// Reply sequencer: holds one reply frame and sends it byte by byte with its CRC.
`default_nettype none

module ccfp_reply
  import ccfp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire reply_req_t          req,
  output logic                     busy,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [BYTE_W-1:0]        tx_byte,
  output logic                     last_byte
);

  logic                   busy_r, busy_nxt;
  logic [REPLY_IDX_W-1:0] idx_r, idx_nxt;
  logic [CRC_W-1:0]       crc_r, crc_nxt;
  logic [BYTE_W-1:0]      bytes_r [0:3];
  logic                   take;

  assign take = busy_r && out_tready;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    crc_nxt  = crc_r;
    if (req.valid) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      crc_nxt  = CRC_INIT;
    end else if (take) begin
      // fold the four header bytes into the reply CRC as they go out
      if (idx_r < RPL_CRC_HI) begin
        crc_nxt = crc16_update(crc_r, bytes_r[idx_r[1:0]]);
      end
      if (idx_r == RPL_CRC_LO) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      crc_r  <= CRC_INIT;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      crc_r  <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      bytes_r[0] <= req.id;
      bytes_r[1] <= req.b1;
      bytes_r[2] <= req.b2;
      bytes_r[3] <= req.b3;
    end
  end

  always_comb begin
    case (idx_r)
      RPL_CRC_HI: tx_byte = crc_r[CRC_W-1:BYTE_W];
      RPL_CRC_LO: tx_byte = crc_r[BYTE_W-1:0];
      default:    tx_byte = bytes_r[idx_r[1:0]];
    endcase
  end

  assign busy       = busy_r;
  assign out_tvalid = busy_r;
  assign last_byte  = busy_r && (idx_r == RPL_CRC_LO);

endmodule

`default_nettype wire

[hw/rtl/crc_checked_frame_parser_top.sv]
// Top level of the CRC-checked frame parser.
//
// Usage:
//   in_*   byte stream in. One received byte per transaction in in_tdata.
//   out_*  reply stream out. Six bytes per good frame: ID, three reply bytes
//          of the matched slot, then the reply CRC-16/CMS high and low byte;
//          out_tlast marks the low CRC byte.
//   cfg_*  register writes: 0 ID table, 1 length table, 2 and 3 reply bytes.
//          Write only while the block is idle.
// Throughput: one input byte per cycle; replies drain at one byte per cycle.
// Latency: the first reply byte is valid the cycle after the CRC low byte of
//   a good frame is taken. The reply CRC is folded in as header bytes leave.
// Stall: the parser keeps taking bytes while a reply drains; only the CRC low
//   byte of the next frame is held off (in_tready low) until the previous
//   reply has fully left. A stalled out_tready holds the current reply byte.
// Reset (rst_n low, synchronous): clear the registers, return to ID hunting
//   and drop any reply in progress.
`default_nettype none

module crc_checked_frame_parser_top
  import ccfp_pkg::*;
#(
  parameter int NUM_IDS = NUM_IDS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [7:0]              in_tdata,    // [7:0] rx_byte
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [7:0]                   out_tdata,   // [7:0] tx_byte
  output logic                         out_tlast,   // last_byte
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [TABLE_W-1:0]      id_table;
  logic [TABLE_W-1:0]      length_table;
  logic [REPLY_LOW_W-1:0]  reply_low;
  logic [REPLY_HIGH_W-1:0] reply_high;
  reply_req_t              req;
  logic                    reply_busy;

  ccfp_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .id_table     (id_table),
    .length_table (length_table),
    .reply_low    (reply_low),
    .reply_high   (reply_high)
  );

  ccfp_parser #(
    .NUM_IDS (NUM_IDS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .rx_byte      (in_tdata),
    .id_table     (id_table),
    .length_table (length_table),
    .reply_low    (reply_low),
    .reply_high   (reply_high),
    .reply_busy   (reply_busy),
    .req          (req)
  );

  ccfp_reply u_reply (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .busy       (reply_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .tx_byte    (out_tdata),
    .last_byte  (out_tlast)
  );

  // A reply never starts on top of one still draining
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> !reply_busy)
    else $error("reply started while previous reply pending");

  // A started reply shows its first byte next cycle, not the last one
  a_start_shows: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |=> (out_tvalid && !out_tlast))
    else $error("reply start did not present the first byte");

  // After the last byte leaves, output goes idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("output still valid after last reply byte");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the CRC-checked frame parser: framed byte traffic in, reply frames out.
`timescale 1ns / 100ps

module testbench;
  import ccfp_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 12;
  localparam int STALL_CYCLES = 300;   // long receiver hold-off for the fill-up test
  localparam int DRAIN_CYCLES = 16;    // settle time once no reply byte is due
  localparam int PHASES       = 2;
  localparam int PHASE_BYTES  = 12;    // random-traffic bytes per configuration phase
  localparam longint WATCHDOG_NS = 2_000_000;

  typedef enum {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [7:0]             out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shadow copies of the configuration registers, updated on each write transaction
  logic [39:0] id_tbl;
  logic [39:0] len_tbl;
  logic [63:0] rpl_low;
  logic [55:0] rpl_high;

  // Parser state as the block should hold it
  parse_state_t p_state;
  logic [2:0]   p_slot;
  logic [7:0]   p_id;
  logic [7:0]   p_len;
  logic [7:0]   p_idx;
  logic [15:0]  p_crc;
  logic [7:0]   p_crc_hi;

  reply_beat_t replies_due[$];
  int          fail_count;
  bit          tx_gaps_on;
  bit          rx_gaps_on;
  bit          stall_request;

  crc_checked_frame_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] rx_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] tx_byte
    .out_tlast  (out_tlast),   // last_byte
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // CRC-16/CMS, one bit at a time, MSB of the byte first
  function automatic logic [15:0] crc_cms_step(input logic [15:0] acc, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ d[i];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ 16'h8005;
      end
    end
    return acc;
  endfunction

  // Advance the parser state by one accepted byte; queue the reply of a good frame
  function automatic void advance_parser(input logic [7:0] b);
    logic [7:0]   want;
    logic [7:0]   frame [0:5];
    logic [15:0]  c;
    logic [119:0] rpl_all;
    int           s;
    reply_beat_t  beat;
    rpl_all = {rpl_high, rpl_low};
    case (p_state)
      ST_WAIT_ID: begin
        s = 0;
        while (s < NUM_IDS_DEF && id_tbl[8*s +: 8] != b) s++;
        if (s < NUM_IDS_DEF) begin
          p_slot  = s[2:0];
          p_id    = b;
          p_idx   = 8'd1;
          p_crc   = crc_cms_step(16'hFFFF, b);
          p_state = ST_WAIT_LEN;
        end
      end
      ST_WAIT_LEN: begin
        want = len_tbl[8*p_slot +: 8];
        if (b == want && want >= MIN_FRAME_LENGTH) begin
          p_len   = b;
          p_idx   = 8'd2;
          p_crc   = crc_cms_step(p_crc, b);
          p_state = ST_WAIT_DATA;
        end else begin
          p_state = ST_WAIT_ID;
          p_idx   = 8'd0;
        end
      end
      ST_WAIT_DATA: begin
        p_crc = crc_cms_step(p_crc, b);
        p_idx = p_idx + 8'd1;
        if (int'(p_idx) + 2 >= int'(p_len)) begin
          p_state = ST_WAIT_CRC_HI;
        end
      end
      ST_WAIT_CRC_HI: begin
        p_crc_hi = b;
        p_idx    = p_idx + 8'd1;
        p_state  = ST_WAIT_CRC_LO;
      end
      ST_WAIT_CRC_LO: begin
        p_state = ST_WAIT_ID;
        p_idx   = 8'd0;
        if ({p_crc_hi, b} == p_crc) begin
          frame[0] = p_id;
          for (int k = 0; k < 3; k++) frame[k + 1] = rpl_all[8*(3*p_slot + k) +: 8];
          c = 16'hFFFF;
          for (int k = 0; k < 4; k++) c = crc_cms_step(c, frame[k]);
          frame[4] = c[15:8];
          frame[5] = c[7:0];
          for (int k = 0; k < 6; k++) begin
            beat.data = frame[k];
            beat.last = (k == 5);
            replies_due.push_back(beat);
          end
        end
      end
      default: begin
        p_state = ST_WAIT_ID;
        p_idx   = 8'd0;
      end
    endcase
  endfunction

  // Check every reply transaction against the oldest due byte, then feed the
  // accepted input byte to the parser model. Both sample pre-edge values, and
  // the reply of a byte can never leave on the edge that takes that byte.
  always @(posedge clk) begin
    reply_beat_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          fail_count++;
          $display("%0t: reply byte with none due: tdata %h tlast %b", $time, out_tdata,
                   out_tlast);
        end else begin
          want = replies_due.pop_front();
          if (out_tdata !== want.data) begin
            fail_count++;
            $display("%0t: tdata mismatch: expected %h actual %h", $time, want.data,
                     out_tdata);
          end
          if (out_tlast !== want.last) begin
            fail_count++;
            $display("%0t: tlast mismatch: expected %b actual %b", $time, want.last,
                     out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        advance_parser(in_tdata);
      end
    end
  end

  // Receiver: random ready, or a long hold-off when a test asks for one
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_tready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end
      out_tready <= !(rx_gaps_on && $urandom_range(99) < 33);
    end
  end

  // Offer one byte and hold it until the input transaction completes.
  // Enter and leave at a falling edge; valid stays high for a following byte.
  task automatic send_byte(input logic [7:0] b);
    while (tx_gaps_on && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every due reply byte, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write one register; valid is left high for a following write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ID_TABLE:     id_tbl   = value[39:0];
      REG_LENGTH_TABLE: len_tbl  = value[39:0];
      REG_REPLY_LOW:    rpl_low  = value;
      REG_REPLY_HIGH:   rpl_high = value[55:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_tables(input logic [39:0] ids, input logic [39:0] lens,
                             input logic [63:0] rlow, input logic [55:0] rhigh);
    write_reg(REG_ID_TABLE, {24'h0, ids});
    write_reg(REG_LENGTH_TABLE, {24'h0, lens});
    write_reg(REG_REPLY_LOW, rlow);
    write_reg(REG_REPLY_HIGH, {8'h0, rhigh});
    cfg_valid <= 1'b0;
  endtask

  // Random tables: mostly short valid lengths, some too short, a few longer
  task automatic randomize_tables();
    logic [39:0] lens;
    int          r;
    for (int s = 0; s < 5; s++) begin
      r = $urandom_range(99);
      if (r < 80) lens[8*s +: 8] = 8'($urandom_range(5, 12));
      else if (r < 90) lens[8*s +: 8] = 8'($urandom_range(0, 4));
      else lens[8*s +: 8] = 8'($urandom_range(13, 40));
    end
    load_tables(40'({$urandom, $urandom}), lens, {$urandom, $urandom},
                56'({$urandom, $urandom}));
  endtask

  // Send a complete frame with its CRC, optionally corrupted
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input bit bad_crc,
                            input fill_t fill);
    logic [15:0] crc;
    logic [7:0]  d;
    crc = crc_cms_step(16'hFFFF, id);
    send_byte(id);
    crc = crc_cms_step(crc, len);
    send_byte(len);
    for (int k = 4; k < int'(len); k++) begin
      case (fill)
        FILL_ZEROS: d = 8'h00;
        FILL_ONES:  d = 8'hFF;
        default:    d = 8'($urandom_range(255));
      endcase
      crc = crc_cms_step(crc, d);
      send_byte(d);
    end
    if (bad_crc) begin
      crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    end
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  // Frame for a slot's ID; the lowest slot with that ID decides the length.
  // A length below the minimum gets only ID and length, which the block rejects.
  task automatic frame_for_slot(input int s, input bit bad_crc);
    logic [7:0] id;
    logic [7:0] len;
    int         w;
    id = id_tbl[8*s +: 8];
    w  = 0;
    while (id_tbl[8*w +: 8] != id) w++;
    len = len_tbl[8*w +: 8];
    if (len < MIN_FRAME_LENGTH) begin
      send_byte(id);
      send_byte(len);
    end else begin
      send_frame(id, len, bad_crc, FILL_RANDOM);
    end
  endtask

  // Reset tables: ID zero matches, but its zero length is too short to accept
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(8'hFF);
    wait_idle();
  endtask

  // Duplicate IDs, bad CRC, a rejected length byte that is not rescanned as an
  // ID, a slot length below the minimum, and data and reply byte extremes
  task automatic test_directed_frames();
    load_tables({8'hFF, 8'h00, 8'h22, 8'h22, 8'h11}, {8'h05, 8'h04, 8'h07, 8'h06, 8'h05},
                64'hFFFF_FFFF_FFFF_FFFF, 56'h0);
    send_frame(8'h11, 8'h05, 1'b0, FILL_ZEROS);
    send_frame(8'h22, 8'h06, 1'b0, FILL_ONES);   // lowest duplicate slot sets the length
    send_frame(8'hFF, 8'h05, 1'b1, FILL_RANDOM);
    send_byte(8'h11);
    send_byte(8'h11);                            // bad length, consumed
    send_byte(8'h00);
    send_byte(8'h04);                            // short slot length never matches
    send_frame(8'hFF, 8'h05, 1'b0, FILL_RANDOM);
    wait_idle();
  endtask

  // All-ones tables: the longest frame and all-ones reply bytes
  task automatic test_longest_frames();
    load_tables({40{1'b1}}, {40{1'b1}}, {64{1'b1}}, {56{1'b1}});
    send_frame(8'hFF, 8'hFF, 1'b0, FILL_RANDOM);
    wait_idle();
  endtask

  // Hold the receiver off while frames keep coming, so the block stalls its input
  task automatic test_backpressure();
    load_tables(40'({$urandom, $urandom}), {5{8'h05}}, {$urandom, $urandom},
                56'({$urandom, $urandom}));
    stall_request = 1'b1;
    for (int n = 0; n < 6; n++) frame_for_slot($urandom_range(4), 1'b0);
    wait_idle();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_full_rate();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    randomize_tables();
    for (int n = 0; n < 4; n++) frame_for_slot($urandom_range(4), $urandom_range(9) == 0);
    wait_idle();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Mostly well-formed frames with random content, mixed with corrupted CRCs,
  // wrong length bytes and noise, over two table settings
  task automatic test_random_traffic();
    int         sent;
    int         r;
    int         s;
    int         w;
    logic [7:0] want;
    for (int ph = 0; ph < PHASES; ph++) begin
      randomize_tables();
      sent = 0;
      while (sent < PHASE_BYTES) begin
        r = $urandom_range(99);
        s = $urandom_range(4);
        if (r < 75) begin
          frame_for_slot(s, r >= 65);
          sent += 8;
        end else if (r < 85) begin
          w = 0;
          while (id_tbl[8*w +: 8] != id_tbl[8*s +: 8]) w++;
          want = len_tbl[8*w +: 8];
          send_byte(id_tbl[8*s +: 8]);
          send_byte(want ^ 8'($urandom_range(1, 255)));
          sent += 2;
        end else begin
          for (int k = $urandom_range(1, 4); k > 0; k--) begin
            send_byte(8'($urandom_range(255)));
            sent++;
          end
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'h00;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ID_TABLE;
    cfg_data      = '0;
    fail_count    = 0;
    tx_gaps_on    = 1'b1;
    rx_gaps_on    = 1'b1;
    stall_request = 1'b0;
    id_tbl        = '0;
    len_tbl       = '0;
    rpl_low       = '0;
    rpl_high      = '0;
    p_state       = ST_WAIT_ID;
    p_slot        = '0;
    p_id          = '0;
    p_len         = '0;
    p_idx         = '0;
    p_crc         = 16'hFFFF;
    p_crc_hi      = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_directed_frames();
    test_longest_frames();
    test_backpressure();
    test_full_rate();
    test_random_traffic();

    if (fail_count == 0) begin
      $display("crc_checked_frame_parser_top regression: pass");
    end else begin
      $display("crc_checked_frame_parser_top regression: fail");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #(WATCHDOG_NS);
    $display("crc_checked_frame_parser_top regression: fail");
    $finish;
  end

endmodule

[crc_checked_frame_parser_top.f]
hw/rtl/ccfp_pkg.sv
hw/rtl/ccfp_cfg_regs.sv
hw/rtl/ccfp_parser.sv
hw/rtl/ccfp_reply.sv
hw/rtl/crc_checked_frame_parser_top.sv
tb/sv/testbench.sv
